// ===== src/thermal_pixel_convert_roi_max_core_assert.svh =====
// ----------------------------------------------------------------------------
// thermal pixel converter assertion macros
// shared property forms for the converter core checks
// ----------------------------------------------------------------------------
`ifndef THERMAL_PIXEL_CONVERT_ROI_MAX_CORE_ASSERT_SVH
`define THERMAL_PIXEL_CONVERT_ROI_MAX_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// shared widths, register indexes and conversion constants
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int RAW_W      = 14;
    localparam int TEMP_W     = 17;
    localparam int CFG_W      = 11;
    localparam int ROI_POS_W  = 10;
    localparam int IDX_W      = 3;
    localparam int POS_OUT_W  = 10;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 56;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROI_LEFT     = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROI_TOP      = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROI_COLS     = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROI_ROWS     = 3'd5;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd512;

    // conversion: hi branch (raw-3300)*20/3, lo branch (raw+7000)*10/3
    localparam logic [RAW_W-1:0] RAW_THRESH = 14'd7300;
    localparam logic [15:0]      RAW_OFS_HI = 16'd3300;
    localparam logic [15:0]      RAW_OFS_LO = 16'd7000;
    localparam logic [17:0]      RECIP_3    = 18'd174763;   // ceil(2^19 / 3)
    localparam int               RECIP_SHIFT = 19;
    localparam logic [18:0]      KELVIN_OFS = 19'd27315;

    typedef struct packed {
        logic restart;
        logic in_roi;
        logic last;
    } flags_t;

    localparam int FLAGS_W = $bits(flags_t);

endpackage

// ===== src/tpc_front.sv =====
// ----------------------------------------------------------------------------
// tpc_front
// config registers, pixel position, region test and count conversion
// ----------------------------------------------------------------------------
module tpc_front #(
    parameter int MAX_WIDTH  = tpc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tpc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [tpc_pkg::IDX_W-1:0]              cfg_addr,
    input  logic [tpc_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                   acc,
    input  logic [tpc_pkg::RAW_W-1:0]              raw_count,
    input  logic                                   frame_start,
    output logic signed [tpc_pkg::TEMP_W-1:0]      e_temp,
    output logic [$clog2(MAX_WIDTH)-1:0]           e_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]          e_row,
    output tpc_pkg::flags_t                        e_flags
);
    import tpc_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int BW    = (WW > HW) ? WW : HW;
    localparam int CMP_W = ((BW > CFG_W) ? BW : CFG_W) + 1;

    logic [CFG_W-1:0]     frame_width_reg, frame_height_reg;
    logic [ROI_POS_W-1:0] roi_left_reg, roi_top_reg;
    logic [CFG_W-1:0]     roi_cols_reg, roi_rows_reg;
    logic [CW-1:0]        col_reg, col_next;
    logic [RW-1:0]        row_reg, row_next;

    logic [CMP_W-1:0] w_x, h_x, col_x, row_x, x0_x, x1_x, y0_x, y1_x;
    logic             full_frame, in_roi, last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            roi_left_reg     <= '0;
            roi_top_reg      <= '0;
            roi_cols_reg     <= '0;
            roi_rows_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_ROI_LEFT:     roi_left_reg     <= cfg_data[ROI_POS_W-1:0];
                REG_ROI_TOP:      roi_top_reg      <= cfg_data[ROI_POS_W-1:0];
                REG_ROI_COLS:     roi_cols_reg     <= cfg_data;
                REG_ROI_ROWS:     roi_rows_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturate frame size to 1..max
    always_comb begin
        if (frame_width_reg == '0) begin
            w_x = CMP_W'(1);
        end else if (CMP_W'(frame_width_reg) > CMP_W'(MAX_WIDTH)) begin
            w_x = CMP_W'(MAX_WIDTH);
        end else begin
            w_x = CMP_W'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_x = CMP_W'(1);
        end else if (CMP_W'(frame_height_reg) > CMP_W'(MAX_HEIGHT)) begin
            h_x = CMP_W'(MAX_HEIGHT);
        end else begin
            h_x = CMP_W'(frame_height_reg);
        end
    end

    // position restarts on frame_start and wraps if the frame shrank under it
    always_comb begin
        col_x = (frame_start || CMP_W'(col_reg) >= w_x) ? '0 : CMP_W'(col_reg);
        row_x = (frame_start || CMP_W'(row_reg) >= h_x) ? '0 : CMP_W'(row_reg);
    end

    assign full_frame = (roi_cols_reg == '0) && (roi_rows_reg == '0);

    always_comb begin
        if (full_frame) begin
            x0_x = '0;
            y0_x = '0;
            x1_x = w_x;
            y1_x = h_x;
        end else begin
            x0_x = CMP_W'(roi_left_reg);
            y0_x = CMP_W'(roi_top_reg);
            x1_x = CMP_W'(roi_left_reg) + CMP_W'(roi_cols_reg);
            y1_x = CMP_W'(roi_top_reg) + CMP_W'(roi_rows_reg);
        end
    end

    assign in_roi = (col_x >= x0_x) && (col_x < x1_x) && (row_x >= y0_x) && (row_x < y1_x);
    assign last   = (col_x == w_x - CMP_W'(1)) && (row_x == h_x - CMP_W'(1));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc) begin
            if (last) begin
                col_next = '0;
                row_next = '0;
            end else if (col_x + CMP_W'(1) >= w_x) begin
                col_next = '0;
                row_next = RW'(row_x + CMP_W'(1));
            end else begin
                col_next = CW'(col_x + CMP_W'(1));
                row_next = RW'(row_x);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // divide by 3 through a reciprocal multiply, exact below 2^19
    logic        hi_branch;
    logic [15:0] base;
    logic [18:0] num10, num;
    logic [36:0] prod;
    logic [17:0] quot;
    logic signed [18:0] temp_wide;

    always_comb begin
        hi_branch = raw_count > RAW_THRESH;
        base      = hi_branch ? (16'(raw_count) - RAW_OFS_HI) : (16'(raw_count) + RAW_OFS_LO);
        num10     = (19'(base) << 3) + (19'(base) << 1);
        num       = hi_branch ? (num10 << 1) : num10;
        prod      = 37'(num) * 37'(RECIP_3);
        quot      = prod[RECIP_SHIFT +: 18];
        temp_wide = signed'({1'b0, quot}) - signed'(KELVIN_OFS);
    end

    assign e_temp          = signed'(temp_wide[TEMP_W-1:0]);
    assign e_col           = CW'(col_x);
    assign e_row           = RW'(row_x);
    assign e_flags.restart = frame_start;
    assign e_flags.in_roi  = in_roi;
    assign e_flags.last    = last;

endmodule

// ===== src/tpc_queue.sv =====
// ----------------------------------------------------------------------------
// tpc_queue
// two-entry queue between the front and the max tracker
// ----------------------------------------------------------------------------
module tpc_queue #(
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              q_valid,
    output logic              q_full,
    output logic [1:0]        q_count
);
    import tpc_pkg::*;

    logic [DATA_W-1:0] data_mem [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            data_mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = data_mem[rd_ptr_reg];
    assign q_valid = count_reg != 2'd0;
    assign q_full  = count_reg == 2'd2;
    assign q_count = count_reg;

endmodule

// ===== src/tpc_back.sv =====
// ----------------------------------------------------------------------------
// tpc_back
// hottest-pixel tracker and result output register
// ----------------------------------------------------------------------------
module tpc_back #(
    parameter int MAX_WIDTH  = tpc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tpc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   q_valid,
    output logic                                   q_pop,
    input  logic signed [tpc_pkg::TEMP_W-1:0]      e_temp,
    input  logic [$clog2(MAX_WIDTH)-1:0]           e_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0]          e_row,
    input  tpc_pkg::flags_t                        e_flags,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic                                   m_tlast,
    output logic signed [tpc_pkg::TEMP_W-1:0]      pixel_temp,
    output logic signed [tpc_pkg::TEMP_W-1:0]      max_temp,
    output logic [tpc_pkg::POS_OUT_W-1:0]          max_col,
    output logic [tpc_pkg::POS_OUT_W-1:0]          max_row
);
    import tpc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic signed [TEMP_W-1:0] best_temp_reg, best_temp_next;
    logic [CW-1:0]            best_col_reg, best_col_next;
    logic [RW-1:0]            best_row_reg, best_row_next;
    logic                     best_valid_reg, best_valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_last_reg;
    logic signed [TEMP_W-1:0] pix_temp_reg, max_temp_reg;
    logic [POS_OUT_W-1:0]     max_col_reg, max_row_reg;

    logic bv, take, new_valid;

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    always_comb begin
        bv             = e_flags.restart ? 1'b0 : best_valid_reg;
        take           = e_flags.in_roi && (!bv || (e_temp > best_temp_reg));
        new_valid      = bv || take;
        best_temp_next = take ? e_temp : best_temp_reg;
        best_col_next  = take ? e_col : best_col_reg;
        best_row_next  = take ? e_row : best_row_reg;
        best_valid_next = new_valid && !e_flags.last;
        out_valid_next = q_pop || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                best_valid_reg <= best_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            best_temp_reg <= best_temp_next;
            best_col_reg  <= best_col_next;
            best_row_reg  <= best_row_next;
            pix_temp_reg  <= e_temp;
            out_last_reg  <= e_flags.last;
            // max fields only on the closing beat of a frame with a candidate
            if (e_flags.last && new_valid) begin
                max_temp_reg <= best_temp_next;
                max_col_reg  <= POS_OUT_W'(best_col_next);
                max_row_reg  <= POS_OUT_W'(best_row_next);
            end else begin
                max_temp_reg <= '0;
                max_col_reg  <= '0;
                max_row_reg  <= '0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tlast    = out_last_reg;
    assign pixel_temp = pix_temp_reg;
    assign max_temp   = max_temp_reg;
    assign max_col    = max_col_reg;
    assign max_row    = max_row_reg;

endmodule

// ===== src/thermal_pixel_convert_roi_max_core.sv =====
// ----------------------------------------------------------------------------
// thermal_pixel_convert_roi_max_core
// raw infrared count to temperature, hottest pixel in a region per frame
// ----------------------------------------------------------------------------
//  channel   dir   ports                        payload
//  ------    ---   -----------------------      -------------------------------
//  s_        in    s_tvalid/s_tready/s_tdata    raw_count; s_tuser frame_start
//  m_        out   m_tvalid/m_tready/m_tdata    temps, max position; m_tlast
//  cfg_      in    cfg_wr_en/cfg_addr/cfg_data  six size and region registers
//
//  one pixel per cycle sustained while m_ is not stalled; the front converts
//  and places a pixel in the queue in the accept cycle, the tracker takes it
//  from the queue and registers the result beat in its output register
//  a stalled m_ fills the two-entry queue, then s_tready drops
//  synchronous active-low reset; no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
module thermal_pixel_convert_roi_max_core #(
    parameter int MAX_WIDTH  = tpc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tpc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tpc_pkg::IDX_W-1:0]         cfg_addr,
    input  logic [tpc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tpc_pkg::S_TDATA_W-1:0]     s_tdata,   // raw_count[13:0]
    input  logic                              s_tuser,   // frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_temp[16:0], max_temp[33:17], max_col[43:34], max_row[53:44]
    output logic [tpc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast    // frame_done
);
    import tpc_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int ENTRY_W = TEMP_W + CW + RW + FLAGS_W;

    logic                     acc;
    logic signed [TEMP_W-1:0] f_temp, b_temp;
    logic [CW-1:0]            f_col, b_col;
    logic [RW-1:0]            f_row, b_row;
    flags_t                   f_flags, b_flags;
    logic [ENTRY_W-1:0]       q_wr_data, q_rd_data;
    logic                     q_valid, q_full, q_pop;
    logic [1:0]               q_count;

    logic signed [TEMP_W-1:0] pixel_temp, max_temp;
    logic [POS_OUT_W-1:0]     max_col, max_row;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;

    tpc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .acc         (acc),
        .raw_count   (s_tdata[RAW_W-1:0]),
        .frame_start (s_tuser),
        .e_temp      (f_temp),
        .e_col       (f_col),
        .e_row       (f_row),
        .e_flags     (f_flags)
    );

    assign q_wr_data = {f_temp, f_col, f_row, f_flags};

    tpc_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (acc),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_valid (q_valid),
        .q_full  (q_full),
        .q_count (q_count)
    );

    assign {b_temp, b_col, b_row, b_flags} = q_rd_data;

    tpc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .e_temp     (b_temp),
        .e_col      (b_col),
        .e_row      (b_row),
        .e_flags    (b_flags),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tlast    (m_tlast),
        .pixel_temp (pixel_temp),
        .max_temp   (max_temp),
        .max_col    (max_col),
        .max_row    (max_row)
    );

    assign m_tdata = {2'b00, max_row, max_col, max_temp, pixel_temp};

`include "thermal_pixel_convert_roi_max_core_assert.svh"

    `TPC_ASSERT_NOW(a_queue_bound, 1'b1, q_count != 2'd3, "queue count past depth")
    `TPC_ASSERT_NEXT(a_beat_held, acc, q_valid || m_tvalid,
        "accepted beat lost between front and output")
    `TPC_ASSERT_NOW(a_max_only_last, m_tvalid && !m_tlast, m_tdata[53:17] == '0,
        "max fields set on a beat that does not close a frame")
    `TPC_ASSERT_NOW(a_pop_needs_entry, q_pop, q_count != 2'd0, "pop from empty queue")

endmodule
